/* rtl/lna_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lna_pkg
// shared types and constants of the leaky integrate-and-fire neuron array
// ----------------------------------------------------------------------------
package lna_pkg;

  localparam int NEURONS = 256;
  localparam int ADDR_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int IDX_W   = 8;
  localparam int CUR_W   = 32;
  localparam int POT_W   = 16;
  localparam int REFR_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // register reset values
  localparam logic signed [POT_W-1:0] REST_RST   = -16'sd17920;  // -70.0 mV
  localparam logic signed [POT_W-1:0] RESETV_RST = -16'sd19200;  // -75.0 mV
  localparam logic signed [POT_W-1:0] THRESH_RST = -16'sd12800;  // -50.0 mV
  localparam logic [15:0]             GAIN_RST   = 16'd205;      // 0.05 Q4.12
  localparam logic [15:0]             SOT_RST    = 16'd8738;     // 1/7.5 Q0.16
  localparam logic [REFR_W-1:0]       REFR_RST   = 8'd2;
  localparam logic signed [POT_W-1:0] INIT_POT   = -16'sd17920;  // membrane after reset

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REST    = 3'd0,
    CFG_RESETV  = 3'd1,
    CFG_THRESH  = 3'd2,
    CFG_GAIN    = 3'd3,
    CFG_SOT     = 3'd4,
    CFG_REFR    = 3'd5,
    CFG_INITPOT = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

  // one neuron entry as held in memory
  typedef struct packed {
    logic                    fired;
    logic [REFR_W-1:0]       refr;
    logic signed [CUR_W-1:0] accum;
    logic signed [POT_W-1:0] membrane;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RST = '{fired: 1'b0, refr: '0, accum: '0, membrane: INIT_POT};

endpackage

/* rtl/lif_neuron_array.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_neuron_array
// array of leaky integrate-and-fire neurons kept in one memory, stepped one
// request at a time by a small sequencer around a shared multiplier
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add-current
// request, a time step of a refractory neuron and a request for a neuron
// outside the array each go through a memory read, then write back and
// result. A full time step goes through a memory read, gain times current on
// the shared 32x17 multiplier, the difference to the target potential, the
// difference times step-over-tau on the same multiplier, then rounding,
// saturation, threshold compare and write back; the two passes through the
// one multiplier make it the longest request. The result is shown for
// exactly one cycle with done_o high, in the same cycle that busy drops; the
// receiver cannot stall it, so it must take every result. The neuron state
// needs no clearing pass after reset: a valid bit per neuron makes an
// untouched neuron read as its reset state.
// ----------------------------------------------------------------------------
module lif_neuron_array
  import lna_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode_i,
  input  logic [IDX_W-1:0]        neuron_index_i,
  input  logic signed [CUR_W-1:0] current_in_i,
  // result channel
  output logic                    done_o,
  output logic [IDX_W-1:0]        neuron_out_o,
  output logic                    spike_o,
  output logic signed [POT_W-1:0] potential_o,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL1,
    ST_DIFF,
    ST_MUL2,
    ST_FIN
  } state_e;

  state_e state_q;

  // configuration registers
  logic signed [POT_W-1:0] rest_q, resetv_q, thresh_q;
  logic [15:0]             gain_q, sot_q;
  logic [REFR_W-1:0]       refr_ticks_q;

  // latched request
  logic                    req_mode_q;
  logic [IDX_W-1:0]        req_idx_q;
  logic signed [CUR_W-1:0] req_cur_q;

  // working registers
  entry_t                  ent_q;
  logic signed [48:0]      prod_q;
  logic signed [31:0]      diff_q;
  logic [NEURONS-1:0]      valid_q;

  // result registers
  logic                    done_q;
  logic [IDX_W-1:0]        nout_q;
  logic                    spike_q;
  logic signed [POT_W-1:0] pot_q;

  logic                    accept;
  logic [ADDR_W-1:0]       addr;
  logic                    in_range;
  logic [ENTRY_W-1:0]      ram_rdata;
  entry_t                  ent;
  logic                    ram_we;
  entry_t                  wr_ent;

  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);
  assign addr     = ADDR_W'(req_idx_q);
  assign in_range = (32'(req_idx_q) < NEURONS);

  lna_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NEURONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (wr_ent),
    .re_i    (accept),
    .raddr_i (ADDR_W'(neuron_index_i)),
    .rdata_o (ram_rdata)
  );

  // untouched neurons read as their reset state
  assign ent = valid_q[addr] ? entry_t'(ram_rdata) : ENTRY_RST;

  // shared multiplier: gain x current, then difference x step-over-tau
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_p;

  assign mul_a = (state_q == ST_MUL2) ? diff_q : ent_q.accum;
  assign mul_b = (state_q == ST_MUL2) ? $signed({1'b0, sot_q}) : $signed({1'b0, gain_q});
  assign mul_p = mul_a * mul_b;

  // target potential and difference, from the gain product (round half up)
  logic signed [48:0] rnd1;
  logic signed [28:0] vterm;
  logic signed [31:0] vinf;
  logic signed [31:0] diff_d;

  assign rnd1   = prod_q + 49'sd524288;
  assign vterm  = rnd1[48:20];
  assign vinf   = {{3{vterm[28]}}, vterm} + {{16{rest_q[15]}}, rest_q};
  assign diff_d = vinf - {{16{ent_q.membrane[15]}}, ent_q.membrane};

  // new potential from the delta product
  logic signed [48:0]      rnd2;
  logic signed [32:0]      delta;
  logic signed [33:0]      vsum;
  logic signed [POT_W-1:0] vsat;
  logic                    fire;

  assign rnd2  = prod_q + 49'sd32768;
  assign delta = rnd2[48:16];
  assign vsum  = {delta[32], delta} + {{18{ent_q.membrane[15]}}, ent_q.membrane};

  always_comb begin
    priority if (vsum > 34'sd32767) begin
      vsat = 16'sd32767;
    end else if (vsum < -34'sd32768) begin
      vsat = -16'sd32768;
    end else begin
      vsat = vsum[15:0];
    end
  end

  assign fire = (vsat >= thresh_q);

  // saturating accumulate for add-current requests
  logic signed [32:0]      sum;
  logic signed [CUR_W-1:0] acc_sat;

  assign sum = {ent.accum[31], ent.accum} + {req_cur_q[31], req_cur_q};

  always_comb begin
    if (sum[32] != sum[31]) begin
      acc_sat = sum[32] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
    end else begin
      acc_sat = sum[31:0];
    end
  end

  // write back
  always_comb begin
    ram_we = 1'b0;
    wr_ent = ent;
    unique case (state_q)
      ST_FETCH: begin
        if (in_range && (req_mode_q == MODE_ADD)) begin
          ram_we       = 1'b1;
          wr_ent.accum = acc_sat;
        end else if (in_range && (ent.refr != '0)) begin
          ram_we          = 1'b1;
          wr_ent.refr     = ent.refr - 1'b1;
          wr_ent.membrane = resetv_q;
          wr_ent.fired    = 1'b0;
          wr_ent.accum    = '0;
        end
      end
      ST_FIN: begin
        ram_we          = 1'b1;
        wr_ent.accum    = '0;
        wr_ent.fired    = fire;
        wr_ent.refr     = fire ? refr_ticks_q : ent_q.refr;
        wr_ent.membrane = fire ? resetv_q : vsat;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer, working and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      done_q       <= 1'b0;
      rest_q       <= REST_RST;
      resetv_q     <= RESETV_RST;
      thresh_q     <= THRESH_RST;
      gain_q       <= GAIN_RST;
      sot_q        <= SOT_RST;
      refr_ticks_q <= REFR_RST;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_REST:    rest_q       <= $signed(cfg_wdata_i);
          CFG_RESETV:  resetv_q     <= $signed(cfg_wdata_i);
          CFG_THRESH:  thresh_q     <= $signed(cfg_wdata_i);
          CFG_GAIN:    gain_q       <= cfg_wdata_i;
          CFG_SOT:     sot_q        <= cfg_wdata_i;
          CFG_REFR:    refr_ticks_q <= cfg_wdata_i[REFR_W-1:0];
          // only the reset value of the initial potential is ever used
          CFG_INITPOT: ;
          default: ;
        endcase
      end

      if (ram_we) begin
        valid_q[addr] <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_mode_q <= mode_i;
            req_idx_q  <= neuron_index_i;
            req_cur_q  <= current_in_i;
            state_q    <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          ent_q  <= ent;
          nout_q <= req_idx_q;
          if (!in_range) begin
            done_q  <= 1'b1;
            spike_q <= 1'b0;
            pot_q   <= '0;
            state_q <= ST_IDLE;
          end else if (req_mode_q == MODE_ADD) begin
            done_q  <= 1'b1;
            spike_q <= ent.fired;
            pot_q   <= ent.membrane;
            state_q <= ST_IDLE;
          end else if (ent.refr != '0) begin
            done_q  <= 1'b1;
            spike_q <= 1'b0;
            pot_q   <= resetv_q;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_q  <= mul_p;
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_q  <= diff_d;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          prod_q  <= mul_p;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          done_q  <= 1'b1;
          spike_q <= fire;
          pot_q   <= fire ? resetv_q : vsat;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign neuron_out_o = nout_q;
  assign spike_o      = spike_q;
  assign potential_o  = pot_q;

endmodule

/* rtl/lna_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lna_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module lna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lna_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lna_checker
// port-level checks of the neuron array request and result sequencing
// ----------------------------------------------------------------------------
module lna_checker
  import lna_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // a taken request keeps the block busy and gives no result in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("request taken but block not busy or result too early");

  // result only shows once busy has dropped
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // busy ends exactly with a result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // one result per request: a strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

bind lif_neuron_array lna_checker u_lna_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

/* dv/tb_lif_neuron_array.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lif_neuron_array
// self-checking bench for the neuron array: an in-bench copy of every neuron's
// membrane, refractory count, current accumulator and fired flag predicts each
// request's report, and the reports that come back are compared in order
// ----------------------------------------------------------------------------
module tb_lif_neuron_array;
  import lna_pkg::*;

  // no register lives at this index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  // slowest run: ~1600 requests, each up to a full time step plus a random idle
  // gap, plus drains and register writes; the limit allows far more
  localparam int CYCLE_LIMIT = 200000;
  // a full time step is the longest request
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [IDX_W-1:0]        neuron;
    logic                    spike;
    logic signed [POT_W-1:0] potential;
  } report_t;

  // block ports
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    mode_i = MODE_ADD;
  logic [IDX_W-1:0]        neuron_index_i = '0;
  logic signed [CUR_W-1:0] current_in_i = '0;
  logic                    done_o;
  logic [IDX_W-1:0]        neuron_out_o;
  logic                    spike_o;
  logic signed [POT_W-1:0] potential_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;

  // predicted neuron memory
  logic signed [POT_W-1:0] membrane_q [NEURONS];
  logic [REFR_W-1:0]       refr_q     [NEURONS];
  logic signed [CUR_W-1:0] accum_q    [NEURONS];
  logic                    fired_q    [NEURONS];

  // predicted register file
  logic signed [POT_W-1:0] cfg_rest   = REST_RST;
  logic signed [POT_W-1:0] cfg_resetv = RESETV_RST;
  logic signed [POT_W-1:0] cfg_thresh = THRESH_RST;
  logic [15:0]             cfg_gain   = GAIN_RST;
  logic [15:0]             cfg_sot    = SOT_RST;
  logic [REFR_W-1:0]       cfg_refr   = REFR_RST;

  report_t          pending_reports [$];
  report_t          oldest_report;
  report_t          seen_report;
  int unsigned      fault_count = 0;
  int unsigned      cycle_count = 0;
  bit               no_gaps = 1'b0;      // set for the back-to-back stretch
  logic [IDX_W-1:0] hot_neurons [4];     // small pool so neurons see long histories

  lif_neuron_array dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .neuron_index_i (neuron_index_i),
    .current_in_i   (current_in_i),
    .done_o         (done_o),
    .neuron_out_o   (neuron_out_o),
    .spike_o        (spike_o),
    .potential_o    (potential_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // neuron prediction: applies one request to the in-bench memory and returns
  // the report the block should give for it
  // ---------------------------------------------------------------------------
  function automatic report_t neuron_update(input mode_e md, input logic [IDX_W-1:0] n,
                                            input logic signed [CUR_W-1:0] cur);
    longint  acc_sum;
    longint  drive;      // gain times accumulated current, Q19.28
    longint  v_target;   // rest plus driven offset, Q8.8, not saturated
    longint  delta;
    longint  v_next;
    report_t r;
    r.neuron = n;
    if (md == MODE_ADD) begin
      // accumulator saturates at the 32-bit limits
      acc_sum = longint'(accum_q[n]) + longint'(cur);
      if (acc_sum > 64'sd2147483647) acc_sum = 64'sd2147483647;
      else if (acc_sum < -64'sd2147483648) acc_sum = -64'sd2147483648;
      accum_q[n] = acc_sum[CUR_W-1:0];
    end else begin
      fired_q[n] = 1'b0;
      if (refr_q[n] != '0) begin
        // refractory: count down, potential pinned at reset level
        refr_q[n] = refr_q[n] - 1'b1;
        membrane_q[n] = cfg_resetv;
      end else begin
        drive    = longint'(cfg_gain) * longint'(accum_q[n]);
        // round half up from Q.28 to Q.8, arithmetic shift floors
        v_target = longint'(cfg_rest) + ((drive + 64'sd524288) >>> 20);
        delta    = ((v_target - longint'(membrane_q[n])) * longint'(cfg_sot)
                    + 64'sd32768) >>> 16;
        v_next   = longint'(membrane_q[n]) + delta;
        if (v_next > 64'sd32767) v_next = 64'sd32767;
        else if (v_next < -64'sd32768) v_next = -64'sd32768;
        if (v_next >= longint'(cfg_thresh)) begin
          fired_q[n] = 1'b1;
          v_next = longint'(cfg_resetv);
          refr_q[n] = cfg_refr;
        end
        membrane_q[n] = v_next[POT_W-1:0];
      end
      accum_q[n] = '0;
    end
    r.spike = fired_q[n];
    r.potential = membrane_q[n];
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      CFG_REST:   cfg_rest   = val;
      CFG_RESETV: cfg_resetv = val;
      CFG_THRESH: cfg_thresh = val;
      CFG_GAIN:   cfg_gain   = val;
      CFG_SOT:    cfg_sot    = val;
      CFG_REFR:   cfg_refr   = val[REFR_W-1:0];
      // initial potential only acts at reset, spare index has no register
      default: ;
    endcase
  endfunction

  // mix of full-range, small, scaled and extreme currents
  function automatic logic signed [CUR_W-1:0] rand_current();
    logic signed [CUR_W-1:0] c;
    case ($urandom_range(0, 4))
      0: c = $urandom;
      1: begin
        c = $urandom_range(0, 131071);
        c = c - 65536;
      end
      2: c = $urandom >> $urandom_range(1, 24);
      3: c = -($urandom >> $urandom_range(1, 24));
      default: c = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // entered at a rising edge; start is left high unless a gap is drawn, so a
  // following request never lowers and raises start in one step
  task automatic send_request(input mode_e md, input logic [IDX_W-1:0] n,
                              input logic signed [CUR_W-1:0] cur);
    start          <= 1'b1;
    mode_i         <= md;
    neuron_index_i <= n;
    current_in_i   <= cur;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // taken at this edge
    pending_reports.push_back(neuron_update(md, n, cur));
    if (!no_gaps && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every report is back and the block is quiet
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // call only while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] rest, input logic [CFG_W-1:0] resetv,
                               input logic [CFG_W-1:0] thresh, input logic [CFG_W-1:0] gain,
                               input logic [CFG_W-1:0] sot, input logic [CFG_W-1:0] refr);
    wait_idle();
    write_reg(CFG_REST, rest);
    write_reg(CFG_RESETV, resetv);
    write_reg(CFG_THRESH, thresh);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_SOT, sot);
    write_reg(CFG_REFR, refr);
  endtask

  // mostly add-then-step sequences on a few neurons, the rest loose requests
  task automatic run_traffic(input int unsigned n_items);
    int unsigned      issued;
    int               k;
    logic [IDX_W-1:0] target;
    issued = 0;
    for (k = 0; k < 4; k++) hot_neurons[2'(k)] = IDX_W'($urandom_range(0, NEURONS-1));
    while (issued < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_request(mode_e'($urandom_range(0, 1)), IDX_W'($urandom_range(0, NEURONS-1)),
                     rand_current());
        issued++;
      end else begin
        target = ($urandom_range(0, 99) < 80) ? hot_neurons[2'($urandom_range(0, 3))]
                                              : IDX_W'($urandom_range(0, NEURONS-1));
        repeat ($urandom_range(0, 3)) begin
          send_request(MODE_ADD, target, rand_current());
          issued++;
        end
        // step carries a random current that must be ignored
        send_request(MODE_STEP, target, rand_current());
        issued++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // untouched neurons report the reset potential; a step at rest stays at rest
  task automatic test_reset_state();
    send_request(MODE_ADD, 8'd0, 32'sd0);
    send_request(MODE_STEP, 8'd255, 32'sd0);
    send_request(MODE_STEP, 8'd0, 32'sd0);
  endtask

  // accumulator clamps at both ends; the high end spikes, the low end
  // drives the potential into its negative limit
  task automatic test_current_saturation();
    send_request(MODE_ADD, 8'd1, 32'sh7FFFFFFF);
    send_request(MODE_ADD, 8'd1, 32'sh7FFFFFFF);
    send_request(MODE_STEP, 8'd1, 32'sh55555555);
    send_request(MODE_ADD, 8'd2, 32'sh80000000);
    send_request(MODE_ADD, 8'd2, 32'sh80000000);
    send_request(MODE_STEP, 8'd2, 32'sh0);
  endtask

  // neuron 1 just fired: two held steps, current added meanwhile is dropped
  task automatic test_refractory();
    send_request(MODE_STEP, 8'd1, 32'sd0);
    send_request(MODE_ADD, 8'd1, 32'sh40000000);
    send_request(MODE_STEP, 8'd1, 32'sd0);
    send_request(MODE_STEP, 8'd1, 32'sd0);
  endtask

  // with no refractory period a neuron can fire on consecutive steps
  task automatic test_zero_refractory();
    wait_idle();
    write_reg(CFG_REFR, '0);
    send_request(MODE_ADD, 8'd3, 32'sh7FFFFFFF);
    send_request(MODE_STEP, 8'd3, 32'sd0);
    send_request(MODE_ADD, 8'd3, 32'sh7FFFFFFF);
    send_request(MODE_STEP, 8'd3, 32'sd0);
  endtask

  // random traffic under defaults, both extremes, a midpoint and random sets
  task automatic test_register_settings();
    int p;
    for (p = 0; p < 9; p++) begin
      case (p)
        0: begin
          load_settings(REST_RST, RESETV_RST, THRESH_RST, GAIN_RST, SOT_RST,
                        {8'h00, REFR_RST});
          // neither write may change behavior after reset
          write_reg(CFG_INITPOT, CFG_W'($urandom));
          write_reg(CFG_SPARE, CFG_W'($urandom));
        end
        // fastest leak, highest threshold, longest refractory period;
        // upper data bits of the refractory write are junk
        1: load_settings(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hA5FF);
        // frozen potential, every free step fires
        2: load_settings(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h5A00);
        3: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001);
        default: load_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                               CFG_W'($urandom), CFG_W'($urandom),
                               {8'($urandom), ($urandom_range(0, 9) == 0) ?
                                8'($urandom) : 8'($urandom_range(0, 6))});
      endcase
      run_traffic(150);
    end
  endtask

  // no gaps at all: requests queue up behind busy, often on the same neuron
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    run_traffic(200);
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // report checking: every cycle with done_o high carries one report
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen_report = '{neuron: neuron_out_o, spike: spike_o, potential: potential_o};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report neuron %0d spike %0b potential %0d",
                 $time, neuron_out_o, spike_o, potential_o);
        fault_count++;
      end else begin
        oldest_report = pending_reports.pop_front();
        if (seen_report !== oldest_report) begin
          $display("%0t: expected neuron %0d spike %0b potential %0d, got neuron %0d spike %0b potential %0d",
                   $time, oldest_report.neuron, oldest_report.spike,
                   oldest_report.potential, neuron_out_o, spike_o, potential_o);
          fault_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** lif_neuron_array: FAILED **");
      $finish;
    end
  end

  initial begin : run_sequence
    int k;
    for (k = 0; k < NEURONS; k++) begin
      membrane_q[ADDR_W'(k)] = INIT_POT;
      refr_q[ADDR_W'(k)]     = '0;
      accum_q[ADDR_W'(k)]    = '0;
      fired_q[ADDR_W'(k)]    = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_current_saturation();
    test_refractory();
    test_zero_refractory();
    test_register_settings();
    test_back_to_back();

    wait_idle();
    if (fault_count == 0) begin
      $display("** lif_neuron_array: PASSED **");
    end else begin
      $display("** lif_neuron_array: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lna_pkg.sv
rtl/lna_ram.sv
rtl/lif_neuron_array.sv
rtl/lna_checker.sv
dv/tb_lif_neuron_array.sv
